/* rtl/sfq_pkg.sv */
package sfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 5;

  localparam logic [1:0] FUNC_ENQ    = 2'd0;
  localparam logic [1:0] FUNC_DEQ    = 2'd1;
  localparam logic [1:0] FUNC_PEEK   = 2'd2;
  localparam logic [1:0] FUNC_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
  } sfq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] head_value;
    logic [POS_W-1:0]         position;
  } sfq_rsp_t;

  // Chain-wide control from the sequencer
  typedef struct packed {
    logic             adv;
    logic             load;
    logic [CNT_W-1:0] occ;
  } sfq_ctl_t;

  // Per-cell control
  typedef struct packed {
    logic adv;
    logic load;
  } sfq_cell_ctl_t;

endpackage

/* rtl/sfq_cell.sv */
module sfq_cell (
  input  logic                         clk_i,
  input  sfq_pkg::sfq_cell_ctl_t       ctl_i,
  input  logic [sfq_pkg::DATA_W-1:0]   nbr_i,
  input  logic [sfq_pkg::DATA_W-1:0]   load_i,
  output logic [sfq_pkg::DATA_W-1:0]   data_o
);
  import sfq_pkg::*;

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.load) begin
      data_q <= load_i;
    end else if (ctl_i.adv) begin
      data_q <= nbr_i;
    end else begin
      data_q <= data_q;
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/sfq_ctrl.sv */
module sfq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  sfq_pkg::sfq_req_t           req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output sfq_pkg::sfq_rsp_t           rsp_o,
  input  logic [sfq_pkg::DATA_W-1:0]  head_i,
  output sfq_pkg::sfq_ctl_t           ctl_o
);
  import sfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              rsp_valid_q, rsp_valid_d;
  sfq_rsp_t          rsp_q, rsp_d;

  logic out_free, accept, hit;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && out_free;
  assign accept      = req_valid_i && req_ready_o;
  // Cell 0 holds entry number step_q while the chain rotates
  assign hit = !found_q && (CNT_W'(step_q) < occ_q) && (head_i == key_q);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    step_d      = step_q;
    key_d       = key_q;
    found_d     = found_q;
    pos_d       = pos_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    ctl_o.adv   = 1'b0;
    ctl_o.load  = 1'b0;
    ctl_o.occ   = occ_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.status     = ST_OK;
          rsp_d.head_value = '0;
          rsp_d.position   = '0;
          if (req_i.func == FUNC_ENQ) begin
            rsp_valid_d = 1'b1;
            if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
              rsp_d.status = ST_FULL;
            end else begin
              ctl_o.load = 1'b1;
              occ_d      = occ_q + 1'b1;
            end
          end else if (occ_q == '0) begin
            rsp_valid_d  = 1'b1;
            rsp_d.status = ST_EMPTY;
          end else if (req_i.func == FUNC_DEQ) begin
            // one rotation step moves the next entry into cell 0
            rsp_valid_d = 1'b1;
            ctl_o.adv   = 1'b1;
            occ_d       = occ_q - 1'b1;
          end else if (req_i.func == FUNC_PEEK) begin
            rsp_valid_d      = 1'b1;
            rsp_d.head_value = head_i;
          end else begin
            key_d   = req_i.value;
            step_d  = '0;
            found_d = 1'b0;
            pos_d   = '0;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // full turn of the ring leaves the order as it was
        ctl_o.adv = 1'b1;
        if (hit) begin
          found_d = 1'b1;
          pos_d   = CNT_W'(step_q) + 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_valid_d      = 1'b1;
          rsp_d.status     = found_q ? ST_OK : ST_NOTFOUND;
          rsp_d.head_value = '0;
          rsp_d.position   = found_q ? POS_W'(pos_q) : '0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    key_q   <= key_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/searchable_fifo_queue.sv */
// Searchable FIFO queue of signed 32-bit values, QUEUE_DEPTH entries deep.
// Request channel (req_valid_i/req_ready_o/req_i) carries func and value:
// enqueue, dequeue, peek or search. Each request yields exactly one
// response transfer on rsp_valid_o/rsp_ready_i/rsp_o with status,
// head_value and position.
// Entries live in a ring of cells; cell 0 is always the head. Enqueue
// writes the cell at the fill count, dequeue rotates the ring one step.
// Enqueue, dequeue and peek responses are registered and appear in the
// cycle after the request is taken. A search rotates the ring a full turn
// in S_SEARCH, comparing the key against cell 0 once per cycle, then
// registers its result from S_DONE. One request is in flight at a time.
// The response sits in an output register; a new request is taken in the
// cycle the previous response is transferred. While the receiver stalls
// a response, no request is accepted and a finished search holds its
// result. Reset empties the queue and drops any pending response;
// cell contents are not cleared.
module searchable_fifo_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  sfq_pkg::sfq_req_t  req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output sfq_pkg::sfq_rsp_t  rsp_o
);
  import sfq_pkg::*;

  sfq_ctl_t          ctl;
  logic [DATA_W-1:0] cell_data [QUEUE_DEPTH];

  sfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .head_i      (cell_data[0]),
    .ctl_o       (ctl)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sfq_cell_ctl_t cell_ctl;

    assign cell_ctl.adv  = ctl.adv;
    assign cell_ctl.load = ctl.load && (ctl.occ == CNT_W'(i));

    sfq_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .nbr_i  (cell_data[(i + 1) % QUEUE_DEPTH]),
      .load_i (req_i.value),
      .data_o (cell_data[i])
    );
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.occ <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds depth");

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> (ctl.occ < CNT_W'(QUEUE_DEPTH)) && !ctl.adv)
    else $error("cell load with full queue or during rotation");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && (req_i.func == FUNC_ENQ) &&
     (ctl.occ == CNT_W'(QUEUE_DEPTH)))
    |=> rsp_valid_o && (rsp_o.status == ST_FULL) && $stable(ctl.occ))
    else $error("enqueue into full queue not refused");
`endif

endmodule

/* tb/sfq_result_checker.sv */
`timescale 1ns / 100ps

module sfq_result_checker
  import sfq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_ready_i,
  input  sfq_req_t req_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_ready_i,
  input  sfq_rsp_t rsp_i,
  output int       pending_o,
  output int       errors_o
);

  // shadow of the queue contents
  logic [DATA_W-1:0] slot_data [QUEUE_DEPTH];
  logic [IDX_W-1:0]  head_slot;
  logic [IDX_W-1:0]  tail_slot;
  logic [CNT_W-1:0]  fill;
  sfq_rsp_t          due_rsp_q [$];
  int                n_err = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    n_err++;
  endtask

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  // apply one request to the shadow queue and return its response
  function automatic sfq_rsp_t queue_op_result(input sfq_req_t r);
    sfq_rsp_t         res;
    logic [IDX_W-1:0] s;
    res = '0;
    res.status = ST_OK;
    if (r.func == FUNC_ENQ) begin
      if (fill == CNT_W'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        slot_data[tail_slot] = r.value;
        tail_slot = ring_next(tail_slot);
        fill = fill + 1'b1;
      end
    end else if (fill == '0) begin
      res.status = ST_EMPTY;
    end else if (r.func == FUNC_DEQ) begin
      head_slot = ring_next(head_slot);
      fill = fill - 1'b1;
    end else if (r.func == FUNC_PEEK) begin
      res.head_value = slot_data[head_slot];
    end else begin
      res.status = ST_NOTFOUND;
      s = head_slot;
      for (int k = 0; k < int'(fill); k++) begin
        if (slot_data[s] == r.value) begin
          res.status   = ST_OK;
          res.position = POS_W'(k + 1);
          break;
        end
        s = ring_next(s);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sfq_rsp_t want;
    if (!rst_ni) begin
      head_slot = '0;
      tail_slot = '0;
      fill      = '0;
      due_rsp_q.delete();
    end else begin
      // response side first: it belongs to an earlier request
      if (rsp_valid_i && rsp_ready_i) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending: %p", rsp_i));
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_i.status, want.status));
          if (rsp_i.head_value !== want.head_value)
            report_mismatch($sformatf("head_value %0h, expected %0h",
                                      rsp_i.head_value, want.head_value));
          if (rsp_i.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      rsp_i.position, want.position));
        end
      end
      if (req_valid_i && req_ready_i)
        due_rsp_q.push_back(queue_op_result(req_i));
    end
    pending_o <= due_rsp_q.size();
    errors_o  <= n_err;
  end

endmodule

/* tb/searchable_fifo_queue_tb.sv */
`timescale 1ns / 100ps

module searchable_fifo_queue_tb;
  import sfq_pkg::*;

  localparam int N_RANDOM    = 600;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;

  logic     clk;
  logic     rst_n;
  logic     req_valid;
  logic     req_ready;
  sfq_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  sfq_rsp_t rsp;
  int       pending;
  int       n_err;
  bit       no_idle;

  logic signed [DATA_W-1:0] key_pool [8];

  searchable_fifo_queue dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  sfq_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_i (req_ready),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_i       (rsp),
    .pending_o   (pending),
    .errors_o    (n_err)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly reuse known keys so searches hit, sometimes a fresh word
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 65)
      return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic issue_req(input logic [1:0] f, input logic signed [DATA_W-1:0] v);
    while (!no_idle && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{func: f, value: v};
    do @(posedge clk); while (!req_ready);
  endtask

  initial begin : rsp_side
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    rsp_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) seen++;
      if (seen == 100 && !held) begin
        // long stall: requests back up behind the held response
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= no_idle || ($urandom_range(99) >= 18);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        idle = 0;
      else
        idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stim
    int                       roll;
    bit                       filling;
    logic [1:0]               f;
    logic signed [DATA_W-1:0] v;
    key_pool = '{32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sh1,
                 32'sh1, 32'sh5a5a0003, 32'sh0000ffff, 32'shffff0000};
    no_idle   = 1'b0;
    rst_n     <= 1'b0;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue
    issue_req(FUNC_DEQ, 32'sh5);
    issue_req(FUNC_PEEK, 32'sh0);
    issue_req(FUNC_SEARCH, 32'sh0);
    // extreme values
    issue_req(FUNC_ENQ, 32'sh80000000);
    issue_req(FUNC_ENQ, 32'sh7fffffff);
    issue_req(FUNC_ENQ, 32'sh0);
    issue_req(FUNC_ENQ, -32'sh1);
    issue_req(FUNC_PEEK, 32'sh0);
    issue_req(FUNC_SEARCH, 32'sh7fffffff);
    issue_req(FUNC_SEARCH, 32'sh12345678);
    // fill up, then overflow
    for (int k = 0; k < 12; k++)
      issue_req(FUNC_ENQ, 32'sh5a5a0000 + k);
    issue_req(FUNC_ENQ, 32'sh11111111);
    issue_req(FUNC_SEARCH, 32'sh5a5a000b);   // match in the last slot
    issue_req(FUNC_DEQ, 32'sh0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 250) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i == 400) no_idle = 1'b1;
      if (i == 480) no_idle = 1'b0;
      // alternate fill-heavy and drain-heavy stretches to hit full and empty
      filling = ((i / 50) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < (filling ? 55 : 15))
        f = FUNC_ENQ;
      else if (roll < 70)
        f = FUNC_DEQ;
      else if (roll < 85)
        f = FUNC_PEEK;
      else
        f = FUNC_SEARCH;
      if (f == FUNC_ENQ && $urandom_range(99) < 40) begin
        v = $urandom;
        key_pool[$urandom_range(7)] = v;
      end else begin
        v = pick_value();
      end
      issue_req(f, v);
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (QUEUE_DEPTH + 4) @(posedge clk);
    if (n_err == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
